FILE: rtl/mlpr_pkg.sv
`default_nettype none

package mlpr_pkg;

    // default network shape
    localparam int H1_SIZE_DEF  = 8;
    localparam int H2_SIZE_DEF  = 16;
    localparam int WBITS_DEF    = 16;

    // neurons held in the weight rom
    localparam int ROM_H1 = 8;
    localparam int ROM_H2 = 16;

    // normalization constants, Q8.8 minima and unsigned Q0.16 reciprocals
    localparam logic signed [16:0] TEMP_MIN_Q   = 17'sd6835;
    localparam logic signed [16:0] HUM_MIN_Q    = 17'sd10243;
    localparam logic signed [16:0] TEMP_RECIP_Q = 17'sd4928;
    localparam logic signed [16:0] HUM_RECIP_Q  = 17'sd1093;
    localparam logic signed [16:0] OUT_RANGE_Q  = 17'sd20206;
    localparam logic signed [23:0] OUT_MIN_Q    = 24'sd6858;

    // operation kinds carried down the multiplier pipeline
    localparam logic [1:0] K_MAC    = 2'd0;
    localparam logic [1:0] K_NORM_T = 2'd1;
    localparam logic [1:0] K_NORM_H = 2'd2;
    localparam logic [1:0] K_DENORM = 2'd3;

    // network phases
    localparam logic [1:0] LY_NORM = 2'd0;
    localparam logic [1:0] LY_ONE  = 2'd1;
    localparam logic [1:0] LY_TWO  = 2'd2;
    localparam logic [1:0] LY_OUT  = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
    } t_uop;

    localparam logic signed [15:0] ROM_W1 [0:15] = '{
        2245, -1500, -9121, 314, -2638, -294, -5022, 14168,
        -5421, 4619, -8731, -5598, 9467, 788, -2785, 7261
    };
    localparam logic signed [15:0] ROM_B1 [0:7] = '{
        4048, -171, 0, -351, -332, -778, 0, -2274
    };
    localparam logic signed [15:0] ROM_W2 [0:127] = '{
        -467, -5124, 5559, 7393, 2269, -7553, -395, 4330,
        -7142, -4645, -2427, -3823, 1688, -5276, -7857, -1111,
        -8858, 3722, -12431, 2844, -9067, -2389, 2328, -10041,
        2171, -3907, 6899, 6362, -1243, -3462, 193, -1085,
        6033, -5849, -3577, -6994, 1940, 3747, -1664, 1715,
        6556, -87, -4716, -3037, -7545, 1555, -4763, -6852,
        873, -845, 1739, 8125, -5888, 5336, 1927, 883,
        -6035, 7403, -1891, -2409, 5320, -266, 7599, 6409,
        3046, -8023, 4367, -7112, 4403, 1962, 2398, 4470,
        2688, 6345, -4209, -5211, 7419, 5423, -1574, -1740,
        -5444, 3195, 7488, 6926, -6467, -4873, 2100, 2229,
        -1460, 3832, 3200, 5328, -6525, -368, -2212, -2203,
        -4641, 7641, 6935, 1815, -5981, -3789, 4960, 5908,
        -6419, -8098, 3267, -1504, -1942, 4120, -3766, -5736,
        -8599, -4775, -6612, 1932, -10736, 6821, 8980, -6427,
        -1960, 8049, 5865, -6842, -3942, -4504, 6800, 5024
    };
    localparam logic signed [15:0] ROM_B2 [0:15] = '{
        599, 0, 491, -450, 840, -5902, -1218, 4242,
        -1464, -1437, -4818, 0, 2530, -833, -1919, -254
    };
    localparam logic signed [15:0] ROM_W3 [0:15] = '{
        -7723, 7625, -4729, -5318, -7814, 5009, 6338, 14657,
        3529, 8338, 5440, -5359, -8875, 7324, 11888, 14378
    };
    localparam logic signed [15:0] ROM_B3 = -16'sd1113;

    // weight of input i into neuron o, zero beyond the rom
    function automatic logic signed [15:0] f_rom_weight(logic [1:0] layer, int i, int o);
        logic signed [15:0] w;
        w = '0;
        unique case (layer)
            LY_ONE: if (i < 2 && o < ROM_H1) w = ROM_W1[i * ROM_H1 + o];
            LY_TWO: if (i < ROM_H1 && o < ROM_H2) w = ROM_W2[i * ROM_H2 + o];
            LY_OUT: if (i < ROM_H2) w = ROM_W3[i];
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic signed [15:0] f_rom_bias(logic [1:0] layer, int o);
        logic signed [15:0] b;
        b = '0;
        unique case (layer)
            LY_ONE: if (o < ROM_H1) b = ROM_B1[o];
            LY_TWO: if (o < ROM_H2) b = ROM_B2[o];
            LY_OUT: b = ROM_B3;
            default: b = '0;
        endcase
        return b;
    endfunction

    // clamp to a signed range of the given width
    function automatic logic signed [15:0] f_weight(logic signed [15:0] w, int bits);
        int lim;
        int v;
        lim = 0;
        v   = int'(w);
        if (bits < 16) begin
            lim = (1 << (bits - 1)) - 1;
            if (v > lim) begin
                v = lim;
            end else if (v < -lim - 1) begin
                v = -lim - 1;
            end
        end
        return 16'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mlpr_alu.sv
`default_nettype none

module mlpr_alu import mlpr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_uop               i_uop,
    input  wire logic signed [16:0] i_op_a,
    input  wire logic signed [16:0] i_op_b,
    input  wire logic               i_acc_ld,
    input  wire logic signed [31:0] i_acc_init,
    output t_uop                    o_res,
    output logic signed [22:0]      o_rnd,
    output logic signed [31:0]      o_acc
);

    t_uop               r_res;
    logic signed [33:0] r_prod;
    logic signed [31:0] r_acc;
    logic signed [31:0] n_acc;
    logic signed [34:0] w_asum;
    logic signed [34:0] w_rsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res <= i_uop;
        end
        r_prod <= 34'(i_op_a) * 34'(i_op_b);
    end

    // saturating add of the registered product
    assign w_asum = {{3{r_acc[31]}}, r_acc} + {r_prod[33], r_prod};

    always_comb begin
        n_acc = r_acc;
        if (i_acc_ld) begin
            n_acc = i_acc_init;
        end else if (r_res.vld && r_res.kind == K_MAC) begin
            if (w_asum[34:31] == 4'b0000 || w_asum[34:31] == 4'b1111) begin
                n_acc = w_asum[31:0];
            end else if (w_asum[34]) begin
                n_acc = {1'b1, 31'd0};
            end else begin
                n_acc = {1'b0, {31{1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // round half up by 12 bits for normalize and de-normalize
    assign w_rsum = {r_prod[33], r_prod} + 35'sd2048;
    assign o_rnd  = w_rsum[34:12];
    assign o_res  = r_res;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

FILE: rtl/mlp_two_input_regressor.sv
`default_nettype none

// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_temperature, i_humidity (Q8.8)
// output    out        o_out_valid / i_out_stall   o_estimate (Q8.8, saturated)
//
// every product goes through one shared 17x17 multiplier whose three-stage
// issue/multiply/accumulate pipe drains at each neuron end.
// o_in_stall is high from accept until the de-normalize step is issued.
// the result sits in an output register; a stall there only holds back the
// de-normalize issue of the following item. synchronous active-low reset
// clears the sequencer, pipe valids, accumulator and output valid.

module mlp_two_input_regressor import mlpr_pkg::*; #(
    parameter int HIDDEN_ONE_SIZE = H1_SIZE_DEF,
    parameter int HIDDEN_TWO_SIZE = H2_SIZE_DEF,
    parameter int WEIGHT_BITS     = WBITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic signed [15:0] i_humidity,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_estimate
);

    // counter and address widths
    localparam int HMAX = (HIDDEN_ONE_SIZE > HIDDEN_TWO_SIZE) ? HIDDEN_ONE_SIZE
                                                              : HIDDEN_TWO_SIZE;
    localparam int IW   = (HMAX > 2) ? $clog2(HMAX) : 1;
    localparam int A1   = (HIDDEN_ONE_SIZE > 1) ? $clog2(HIDDEN_ONE_SIZE) : 1;
    localparam int A2   = (HIDDEN_TWO_SIZE > 1) ? $clog2(HIDDEN_TWO_SIZE) : 1;

    localparam logic [IW-1:0] PAIR_LAST = IW'(1);
    localparam logic [IW-1:0] H1_LAST   = IW'(HIDDEN_ONE_SIZE - 1);
    localparam logic [IW-1:0] H2_LAST   = IW'(HIDDEN_TWO_SIZE - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAC    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DENORM = 2'd3;

    // operand a source at the multiplier
    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_H1  = 2'd1;
    localparam logic [1:0] SRC_H2  = 2'd2;

    function automatic logic signed [15:0] f_sat16(logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // sequencer
    logic [1:0]         r_state, n_state;
    logic [1:0]         r_layer, n_layer;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_o, n_o;
    logic [IW-1:0]      w_i_last;
    logic               w_accept;
    logic               w_drained;
    logic               w_out_free;

    // captured sample and normalized inputs
    logic signed [15:0] r_temp;
    logic signed [15:0] r_hum;
    logic signed [15:0] r_x0;
    logic signed [15:0] r_x1;

    // hidden activations
    logic signed [15:0] r_hidden_one [HIDDEN_ONE_SIZE];
    logic signed [15:0] r_hidden_two [HIDDEN_TWO_SIZE];
    logic signed [15:0] r_h1_rd;
    logic signed [15:0] r_h2_rd;
    logic               w_h1_we;
    logic               w_h2_we;

    // issue stage
    t_uop               r_s1, n_s1;
    logic [1:0]         r_s1_src, n_s1_src;
    logic signed [16:0] r_s1_a, n_s1_a;
    logic signed [16:0] r_s1_b, n_s1_b;
    logic signed [15:0] w_wgt;
    logic signed [15:0] w_bias;
    logic signed [31:0] w_acc_init;
    logic               w_acc_ld;
    logic signed [16:0] w_op_a;

    // shared unit results
    t_uop               w_res;
    logic signed [22:0] w_rnd;
    logic signed [31:0] w_acc;
    logic signed [32:0] w_acc_r;
    logic signed [15:0] w_acc_q;
    logic signed [15:0] w_relu;

    // output register
    logic               r_out_vld;
    logic signed [15:0] r_est;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_drained  = (r_state == ST_DRAIN) && !r_s1.vld && !w_res.vld;
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_h1_we    = w_drained && (r_layer == LY_ONE);
    assign w_h2_we    = w_drained && (r_layer == LY_TWO);

    // accumulator value rounded by 14 to Q4.12, saturated, then relu
    assign w_acc_r = {w_acc[31], w_acc} + 33'sd8192;
    assign w_acc_q = f_sat16({{5{w_acc_r[32]}}, w_acc_r[32:14]});
    assign w_relu  = w_acc_q[15] ? 16'sd0 : w_acc_q;

    // last input index of the current phase
    always_comb begin
        unique case (r_layer)
            LY_NORM: w_i_last = PAIR_LAST;
            LY_ONE:  w_i_last = PAIR_LAST;
            LY_TWO:  w_i_last = H1_LAST;
            LY_OUT:  w_i_last = H2_LAST;
            default: w_i_last = PAIR_LAST;
        endcase
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_layer = r_layer;
        n_i     = r_i;
        n_o     = r_o;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MAC;
                    n_layer = LY_NORM;
                    n_i     = '0;
                    n_o     = '0;
                end
            end
            ST_MAC: begin
                if (r_i == w_i_last) begin
                    n_i     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (w_drained) begin
                    unique case (r_layer)
                        LY_NORM: begin
                            n_layer = LY_ONE;
                            n_o     = '0;
                            n_state = ST_MAC;
                        end
                        LY_ONE: begin
                            n_state = ST_MAC;
                            if (r_o == H1_LAST) begin
                                n_layer = LY_TWO;
                                n_o     = '0;
                            end else begin
                                n_o = r_o + IW'(1);
                            end
                        end
                        LY_TWO: begin
                            n_state = ST_MAC;
                            if (r_o == H2_LAST) begin
                                n_layer = LY_OUT;
                                n_o     = '0;
                            end else begin
                                n_o = r_o + IW'(1);
                            end
                        end
                        LY_OUT: begin
                            n_state = ST_DENORM;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DENORM: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_layer <= LY_NORM;
            r_i     <= '0;
            r_o     <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_i     <= n_i;
            r_o     <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_temp <= i_temperature;
            r_hum  <= i_humidity;
        end
    end

    // rom fetch for the current input/neuron pair
    assign w_wgt      = f_weight(f_rom_weight(r_layer, int'(r_i), int'(r_o)), WEIGHT_BITS);
    assign w_bias     = f_weight(f_rom_bias(r_layer, int'(r_o)), WEIGHT_BITS);
    assign w_acc_init = {{4{w_bias[15]}}, w_bias, 12'd0};

    // bias preload on the first issue of a neuron, pipe is empty then
    assign w_acc_ld = (r_state == ST_MAC) && (r_i == '0) && (r_layer != LY_NORM);

    // issue: build one multiplier operation per cycle in the mac state, none while draining
    always_comb begin
        n_s1.vld  = 1'b0;
        n_s1.kind = K_MAC;
        n_s1_src  = SRC_REG;
        n_s1_a    = '0;
        n_s1_b    = {w_wgt[15], w_wgt};
        if (r_state == ST_MAC) begin
            n_s1.vld = 1'b1;
            unique case (r_layer)
                LY_NORM: begin
                    if (r_i == '0) begin
                        n_s1.kind = K_NORM_T;
                        n_s1_a    = {r_temp[15], r_temp} - TEMP_MIN_Q;
                        n_s1_b    = TEMP_RECIP_Q;
                    end else begin
                        n_s1.kind = K_NORM_H;
                        n_s1_a    = {r_hum[15], r_hum} - HUM_MIN_Q;
                        n_s1_b    = HUM_RECIP_Q;
                    end
                end
                LY_ONE: begin
                    n_s1_a = (r_i == '0) ? {r_x0[15], r_x0} : {r_x1[15], r_x1};
                end
                LY_TWO: n_s1_src = SRC_H1;
                LY_OUT: n_s1_src = SRC_H2;
                default: n_s1_src = SRC_REG;
            endcase
        end else if (r_state == ST_DENORM && w_out_free) begin
            n_s1.vld  = 1'b1;
            n_s1.kind = K_DENORM;
            n_s1_a    = {w_acc_q[15], w_acc_q};
            n_s1_b    = OUT_RANGE_Q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
        r_s1_src <= n_s1_src;
        r_s1_a   <= n_s1_a;
        r_s1_b   <= n_s1_b;
    end

    // hidden activation memories, registered read alongside the issue stage
    always_ff @(posedge i_clk) begin
        if (w_h1_we) begin
            r_hidden_one[r_o[A1-1:0]] <= w_relu;
        end
        r_h1_rd <= r_hidden_one[r_i[A1-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_h2_we) begin
            r_hidden_two[r_o[A2-1:0]] <= w_relu;
        end
        r_h2_rd <= r_hidden_two[r_i[A2-1:0]];
    end

    always_comb begin
        unique case (r_s1_src)
            SRC_H1:  w_op_a = {r_h1_rd[15], r_h1_rd};
            SRC_H2:  w_op_a = {r_h2_rd[15], r_h2_rd};
            default: w_op_a = r_s1_a;
        endcase
    end

    // shared multiplier and saturating accumulator
    mlpr_alu u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (r_s1),
        .i_op_a     (w_op_a),
        .i_op_b     (r_s1_b),
        .i_acc_ld   (w_acc_ld),
        .i_acc_init (w_acc_init),
        .o_res      (w_res),
        .o_rnd      (w_rnd),
        .o_acc      (w_acc)
    );

    // retire normalize and de-normalize results
    always_ff @(posedge i_clk) begin
        if (w_res.vld && w_res.kind == K_NORM_T) begin
            r_x0 <= f_sat16({w_rnd[22], w_rnd});
        end
        if (w_res.vld && w_res.kind == K_NORM_H) begin
            r_x1 <= f_sat16({w_rnd[22], w_rnd});
        end
        if (w_res.vld && w_res.kind == K_DENORM) begin
            r_est <= f_sat16({w_rnd[22], w_rnd} + OUT_MIN_Q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res.vld && w_res.kind == K_DENORM) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_estimate  = r_est;

    // bias preload never collides with a product landing in the accumulator
    a_acc_ld_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_ld |-> !(w_res.vld && w_res.kind == K_MAC))
        else $error("bias preload collides with accumulate");

    // a finished estimate only lands in a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.vld && w_res.kind == K_DENORM) |-> !r_out_vld)
        else $error("estimate overwrites a pending result");

    // output valid comes only from a de-normalize retire
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_res.vld && w_res.kind == K_DENORM))
        else $error("output valid without a retired estimate");

    // writeback happens only with the pipe empty
    a_wb_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_h1_we || w_h2_we) |-> (!r_s1.vld && !w_res.vld && !w_acc_ld))
        else $error("hidden writeback with work in flight");

endmodule

`default_nettype wire
